[rtl/fpa_pkg.sv]
// ============================================================================
// fpa_pkg: shared types and constants
// Request and response formats, opcodes and the classified item that
// travels from the front end through the queue to the execution pipeline.
// ============================================================================
`default_nettype none

package fpa_pkg;

    localparam int DEFAULT_FRAC_BITS = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    // How the execution pipeline finishes an item.
    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_zero;
    } rsp_t;

    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] simple;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } cls_t;

endpackage

`default_nettype wire

[rtl/fpa_front.sv]
// ============================================================================
// fpa_front: request register and classifier
// Takes one request per cycle while not stalled, computes flags, magnitudes
// and the result of every simple operation, and hands the item to the queue.
// ============================================================================
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fpa_pkg::req_t req_data,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire logic          q_full,
    output logic               q_push,
    output fpa_pkg::cls_t      q_item
);
    import fpa_pkg::*;

    logic front_valid_reg;
    cls_t front_reg;
    cls_t front_next;

    always_comb
    begin : classify
        logic [31:0] ua;
        logic [31:0] ub;
        ua = req_data.operand_a;
        ub = req_data.operand_b;
        front_next        = '0;
        front_next.kind   = KIND_SIMPLE;
        front_next.lt     = $signed(ua) < $signed(ub);
        front_next.eq     = ua == ub;
        front_next.gt     = $signed(ua) > $signed(ub);
        front_next.neg    = ua[31] ^ ub[31];
        front_next.mag_a  = ua[31] ? (32'd0 - ua) : ua;
        front_next.mag_b  = ub[31] ? (32'd0 - ub) : ub;
        unique case (op_t'(req_data.func))
            OP_ADD:      front_next.simple = ua + ub;
            OP_SUB:      front_next.simple = ua - ub;
            OP_MUL:      front_next.kind = KIND_MUL;
            OP_DIV:
            begin
                if (ub == 32'd0)
                begin
                    front_next.dz = 1'b1;
                end
                else
                begin
                    front_next.kind = KIND_DIV;
                end
            end
            OP_MIN:      front_next.simple = front_next.lt ? ua : ub;
            OP_MAX:      front_next.simple = front_next.gt ? ua : ub;
            OP_INC:      front_next.simple = ua + 32'd1;
            OP_DEC:      front_next.simple = ua - 32'd1;
            OP_FROM_INT: front_next.simple = ua << FRAC_BITS;
            OP_TO_INT:   front_next.simple = 32'($signed(ua) >>> FRAC_BITS);
            default:     front_next.simple = 32'd0;
        endcase
    end

    assign req_stall = front_valid_reg && q_full;
    assign q_push    = front_valid_reg && !q_full;
    assign q_item    = front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (req_valid && !req_stall)
        begin
            front_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            front_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            front_reg <= front_next;
        end
    end

endmodule

`default_nettype wire

[rtl/fpa_queue.sv]
// ============================================================================
// fpa_queue: short queue between front end and execution pipeline
// A small circular buffer that lets either side stall on its own.
// ============================================================================
`default_nettype none

module fpa_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire fpa_pkg::cls_t push_item,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output fpa_pkg::cls_t      head_item
);
    import fpa_pkg::*;

    cls_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_pop;

    assign full       = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/fpa_back.sv]
// ============================================================================
// fpa_back: execution pipeline
// Multiplies in the first stage, runs a restoring divider two quotient bits
// per stage, rounds, and applies the sign in the output register.
// ============================================================================
`default_nettype none

module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire fpa_pkg::cls_t head_item,
    output logic               pop,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fpa_pkg::rsp_t      rsp_data
);
    import fpa_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DS    = (NUM_W + 1) / 2;
    localparam int NS    = DS + 2;
    localparam logic [63:0] HALF = 64'(64'd1 << FRAC_BITS) >> 1;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic             neg;
        logic [31:0]      d;
        logic [32:0]      rem;
        logic [NUM_W-1:0] nq;
        logic [63:0]      prod;
        logic [31:0]      res;
        logic             lt;
        logic             eq;
        logic             gt;
        logic             dz;
    } stg_t;

    stg_t  pipe_reg  [NS];
    stg_t  pipe_next [NS];
    logic  adv;
    logic  out_valid_reg;
    rsp_t  out_reg;
    rsp_t  out_next;

    assign adv = !out_valid_reg || !rsp_stall;
    assign pop = adv;

    always_comb
    begin
        pipe_next[0]       = '0;
        pipe_next[0].valid = head_valid;
        pipe_next[0].kind  = head_item.kind;
        pipe_next[0].neg   = head_item.neg;
        pipe_next[0].d     = head_item.mag_b;
        pipe_next[0].rem   = '0;
        pipe_next[0].nq    = NUM_W'({head_item.mag_a, {FRAC_BITS{1'b0}}});
        pipe_next[0].prod  = head_item.mag_a * head_item.mag_b;
        pipe_next[0].res   = head_item.simple;
        pipe_next[0].lt    = head_item.lt;
        pipe_next[0].eq    = head_item.eq;
        pipe_next[0].gt    = head_item.gt;
        pipe_next[0].dz    = head_item.dz;
    end

    for (genvar k = 1; k <= DS; k++)
    begin : g_div
        always_comb
        begin : step
            stg_t        t;
            logic [32:0] sh;
            logic        qb;
            t = pipe_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                if ((k - 1) * 2 + j < NUM_W)
                begin
                    sh = {t.rem[31:0], t.nq[NUM_W-1]};
                    qb = sh >= {1'b0, t.d};
                    t.rem = qb ? (sh - {1'b0, t.d}) : sh;
                    t.nq  = {t.nq[NUM_W-2:0], qb};
                end
            end
            // The product is rounded alongside the first divider stage.
            if (k == 1 && t.kind == KIND_MUL)
            begin
                t.res = 32'((t.prod + HALF) >> FRAC_BITS);
            end
            pipe_next[k] = t;
        end
    end

    always_comb
    begin : round_div
        stg_t t;
        t = pipe_reg[DS];
        if (t.kind == KIND_DIV)
        begin
            t.res = t.nq[31:0] + 32'({t.rem, 1'b0} >= {2'b00, t.d});
        end
        pipe_next[NS-1] = t;
    end

    always_comb
    begin
        out_next.result    = (pipe_reg[NS-1].kind != KIND_SIMPLE && pipe_reg[NS-1].neg) ?
                             (32'd0 - pipe_reg[NS-1].res) : pipe_reg[NS-1].res;
        out_next.a_less    = pipe_reg[NS-1].lt;
        out_next.a_equal   = pipe_reg[NS-1].eq;
        out_next.a_greater = pipe_reg[NS-1].gt;
        out_next.div_zero  = pipe_reg[NS-1].dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                pipe_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pipe_reg[0] <= pipe_next[0];
            for (int i = 1; i < NS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
            out_valid_reg <= pipe_reg[NS-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

[rtl/fixed_point_alu_q24_8.sv]
// ============================================================================
// fixed_point_alu_q24_8: signed 32-bit fixed-point ALU
// Add, subtract, multiply, divide, min, max, increment, decrement and
// integer conversions on raw fixed-point operands with FRAC_BITS fraction.
// ============================================================================
// Usage: a request (func, operand_a, operand_b) is taken on req_data when
// req_valid is high and req_stall is low. Each request yields exactly one
// response on rsp_data, taken when rsp_valid is high and rsp_stall is low.
// Responses leave in request order.
// Throughput is one request per cycle for every opcode while the receiver
// does not stall. A request passes through the request register, the queue,
// the pipeline stages and the output register. The divider resolves two
// quotient bits per stage, and every opcode travels the same pipeline.
// Product and quotient are rounded to nearest with ties away from zero and
// wrap to 32 bits. Division by zero returns 0 with div_zero set.
// Reset empties the request register, the two-entry queue and the pipeline;
// no response is pending after reset.
// When a response is stalled, the whole execution pipeline holds, the queue
// fills, and req_stall rises once the request register cannot drain.
// ============================================================================
`default_nettype none

module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire fpa_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fpa_pkg::rsp_t      rsp_data
);
    import fpa_pkg::*;

    // Front end to queue.
    logic q_push;
    logic q_full;
    cls_t q_item;

    // Queue to execution pipeline.
    logic head_valid;
    cls_t head_item;
    logic q_pop;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

`ifndef NO_ASSERTIONS
    // A division by zero always carries a zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.div_zero |-> rsp_data.result == 32'd0)
        else $error("div_zero response with nonzero result");

    // Exactly one comparison flag is set on every response.
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot({rsp_data.a_less, rsp_data.a_equal, rsp_data.a_greater}))
        else $error("comparison flags not one-hot");

    // Requests are held back only when the queue is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> q_full)
        else $error("request stalled while queue has room");
`endif

endmodule

`default_nettype wire

[tb/fixed_point_alu_q24_8_tb.sv]
// ============================================================================
// fixed_point_alu_q24_8_tb: self-checking testbench for the fixed-point ALU
// Sends directed corner requests and then random ones, stalls the response
// side at random and once for a long stretch, and compares each response
// with a predictor that computes the exact rounded arithmetic.
// ============================================================================
`default_nettype none

module fixed_point_alu_q24_8_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    localparam int FRAC     = DEFAULT_FRAC_BITS;
    localparam int LATENCY  = (32 + FRAC + 1) / 2 + 5;
    localparam int N_RANDOM = 500;

    // Predicts ALU responses and keeps the ones still owed by the block.
    class alu_scoreboard;
        rsp_t pending[$];
        int   mismatches;
        int   checked;

        // Magnitude of a signed 32-bit value, as 64 bits.
        static function logic [63:0] magnitude(logic signed [31:0] x);
            logic [63:0] m;
            m = {{32{x[31]}}, x};
            if (x[31])
                m = -m;
            return {32'd0, m[31:0]};
        endfunction

        static function logic [31:0] apply_sign(logic [63:0] m, logic neg);
            return neg ? -m[31:0] : m[31:0];
        endfunction

        static function rsp_t compute(req_t r);
            rsp_t               e;
            logic signed [31:0] a;
            logic signed [31:0] b;
            logic [63:0]        p;
            logic [63:0]        q;
            logic [63:0]        rem;
            logic               neg;
            a   = r.operand_a;
            b   = r.operand_b;
            neg = a[31] ^ b[31];
            e   = '0;
            case (r.func)
                OP_ADD: e.result = a + b;
                OP_SUB: e.result = a - b;
                OP_MUL:
                begin
                    p = magnitude(a) * magnitude(b);
                    if (FRAC > 0)
                        p = p + (64'd1 << (FRAC - 1));
                    e.result = apply_sign(p >> FRAC, neg);
                end
                OP_DIV:
                begin
                    if (b == 0)
                    begin
                        e.div_zero = 1'b1;
                        e.result   = '0;
                    end
                    else
                    begin
                        p   = magnitude(a) << FRAC;
                        q   = p / magnitude(b);
                        rem = p % magnitude(b);
                        if (2 * rem >= magnitude(b))
                            q = q + 1;
                        e.result = apply_sign(q, neg);
                    end
                end
                OP_MIN: e.result = (a < b) ? a : b;
                OP_MAX: e.result = (a > b) ? a : b;
                OP_INC: e.result = a + 1;
                OP_DEC: e.result = a - 1;
                OP_FROM_INT: e.result = a <<< FRAC;
                OP_TO_INT: e.result = a >>> FRAC;
                default: e.result = '0;
            endcase
            e.a_less    = a < b;
            e.a_equal   = a == b;
            e.a_greater = a > b;
            return e;
        endfunction

        function void note_request(req_t r);
            pending.push_back(compute(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result || got.a_less !== want.a_less ||
                got.a_equal !== want.a_equal || got.a_greater !== want.a_greater ||
                got.div_zero !== want.div_zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d expected %p got %p",
                             checked, want, got);
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b1;
    rsp_t  rsp_data;

    alu_scoreboard board;
    int    requests_sent;
    bit    long_holdoff_wanted;
    bit    stimulus_done;

    always #1 clk = ~clk;

    fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random operand that favors edge values so both signs and extremes appear.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'h0000_0100 : 32'hFFFF_FF00;
            4, 5: return $signed($urandom_range(0, 4095)) - 2048;
            6: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic send_request(logic [3:0] func, logic [31:0] a, logic [31:0] b);
        req_t r;
        r.func      = func;
        r.operand_a = a;
        r.operand_b = b;
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
        requests_sent++;
    endtask

    task automatic idle_request_side(int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Response side: accepted responses are checked at the clock edge, and
    // the stall for the next edge is chosen right after.
    initial
    begin : response_side
        int gap;
        int holdoff;
        gap = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp_data);
            if (long_holdoff_wanted)
            begin
                // A long hold-off fills the pipeline and the queue so that
                // the block has to push back on the request side.
                long_holdoff_wanted = 1'b0;
                rsp_stall <= 1'b1;
                for (holdoff = 0; holdoff < 80; holdoff++)
                    @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                gap = stimulus_done ? 0 : gap_length();
                rsp_stall <= gap > 0;
            end
        end
    end

    initial
    begin : run_limit
        #2000000;
        $display("ERROR: timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int          i;
        int          drained;
        logic [31:0] a;
        logic [31:0] b;
        logic [3:0]  func;
        board = new();
        requests_sent = 0;
        long_holdoff_wanted = 1'b0;
        stimulus_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, every opcode, unused opcodes, divide by
        // zero, rounding ties for multiply and divide, and the flags.
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_MUL, 32'h0000_0180, 32'h0000_0001);
        send_request(OP_MUL, 32'hFFFF_FE80, 32'h0000_0001);
        send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_DIV, 32'h0000_0100, 32'h0000_0000);
        send_request(OP_DIV, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
        send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_MIN, 32'h0000_0005, 32'h0000_0005);
        send_request(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_DEC, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_FROM_INT, 32'h00FF_FFFF, 32'h0000_0000);
        send_request(OP_FROM_INT, 32'h8000_0001, 32'h0000_0000);
        send_request(OP_TO_INT, 32'hFFFF_FF01, 32'h0000_0000);
        send_request(OP_TO_INT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(4'd10, 32'h1234_5678, 32'h1234_5678);
        send_request(4'd15, 32'hFFFF_FFFF, 32'h0000_0000);

        // Random part, with one long receiver hold-off partway through
        // while requests keep coming back to back.
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
                long_holdoff_wanted = 1'b1;
            func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            a = pick_operand();
            b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
            send_request(func, a, b);
            if (i < N_RANDOM / 3 || i > N_RANDOM / 3 + 40)
                idle_request_side(gap_length());
        end
        req_valid <= 1'b0;
        stimulus_done = 1'b1;

        drained = 0;
        while (board.pending.size() != 0 && drained < 100000)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (LATENCY * 4) @(posedge clk);

        $display("Sent %0d requests covering all opcodes, unused codes and corners;",
                 requests_sent);
        $display("checked %0d responses under random and long response stalls.",
                 board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("ERROR: %0d mismatches, %0d responses missing",
                     board.mismatches, board.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[fixed_point_alu_q24_8.f]
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_alu_q24_8.sv
tb/fixed_point_alu_q24_8_tb.sv
